// File: rtl/core/ssd_pkg.sv
package ssd_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_DIGIT_PERIOD       = 2'd0,
    CFG_BRIGHTNESS_PERCENT = 2'd1,
    CFG_SEGMENT_ACTIVE_LOW = 2'd2,
    CFG_DIGIT_ACTIVE_LOW   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] char_code;
    logic [1:0] start_position;
  } item_t;

  localparam int          PERIOD_W        = 16;
  localparam int          PERCENT_W       = 7;
  localparam int          PROD_W          = 23;
  localparam int          SEL_W           = 3;
  localparam logic [6:0]  CHAR_DOT        = 7'h2E;
  localparam logic [15:0] PERIOD_RESET    = 16'd255;
  localparam logic [6:0]  PERCENT_RESET   = 7'd100;
  localparam logic [PROD_W-1:0] PERCENT_FULL = PROD_W'(100);

  // ascii to segment byte, bit0 is segment a, bit7 the dot
  function automatic logic [7:0] seg_lookup(input logic [6:0] c);
    logic [7:0] s;
    case (c)
      7'd45:   s = 8'h40;
      7'd46:   s = 8'h80;
      7'd48:   s = 8'h3F;
      7'd49:   s = 8'h06;
      7'd50:   s = 8'h5B;
      7'd51:   s = 8'h4F;
      7'd52:   s = 8'h66;
      7'd53:   s = 8'h6D;
      7'd54:   s = 8'h7D;
      7'd55:   s = 8'h07;
      7'd56:   s = 8'h7F;
      7'd57:   s = 8'h6F;
      7'd60:   s = 8'h18;
      7'd61:   s = 8'h48;
      7'd62:   s = 8'h0C;
      7'd65:   s = 8'h77;
      7'd67:   s = 8'h39;
      7'd69:   s = 8'h79;
      7'd70:   s = 8'h71;
      7'd71:   s = 8'h3D;
      7'd72:   s = 8'h76;
      7'd73:   s = 8'h06;
      7'd74:   s = 8'h1F;
      7'd76:   s = 8'h38;
      7'd79:   s = 8'h3F;
      7'd80:   s = 8'h73;
      7'd83:   s = 8'h6D;
      7'd84:   s = 8'h78;
      7'd85:   s = 8'h3E;
      7'd86:   s = 8'h1C;
      7'd89:   s = 8'h6E;
      7'd91:   s = 8'h39;
      7'd93:   s = 8'h0F;
      7'd94:   s = 8'h09;
      7'd95:   s = 8'h08;
      7'd98:   s = 8'h7C;
      7'd99:   s = 8'h58;
      7'd100:  s = 8'h5E;
      7'd102:  s = 8'h71;
      7'd104:  s = 8'h74;
      7'd106:  s = 8'h0E;
      7'd110:  s = 8'h54;
      7'd111:  s = 8'h5C;
      7'd114:  s = 8'h50;
      7'd116:  s = 8'h78;
      7'd117:  s = 8'h1C;
      7'd118:  s = 8'h1C;
      7'd123:  s = 8'h46;
      7'd125:  s = 8'h70;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/ssd_store.sv
module ssd_store import ssd_pkg::*; #(
  parameter int DIGITS = 3,
  localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  item_t              item,
  input  logic [DIGIT_W-1:0] rd_digit,
  output logic [7:0]         rd_seg
);

  localparam int POS_MAX = (DIGITS > 3) ? DIGITS : 3;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam logic [POS_W-1:0] POS_END = POS_W'(DIGITS);

  logic [7:0]       store_r [DIGITS];
  logic [7:0]       store_nxt [DIGITS];
  logic [POS_W-1:0] wp_r, wp_nxt;
  logic             done_r, done_nxt;
  logic             merge_r, merge_nxt;
  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] wp_inc;

  assign last_pos = wp_r - POS_W'(1);
  assign wp_inc   = wp_r + POS_W'(1);

  always_comb begin
    store_nxt = store_r;
    wp_nxt    = wp_r;
    done_nxt  = done_r;
    merge_nxt = merge_r;
    if (upd) begin
      case (item.cmd)
        CMD_START: begin
          wp_nxt    = POS_W'(item.start_position);
          done_nxt  = (POS_W'(item.start_position) >= POS_END);
          merge_nxt = 1'b0;
        end
        CMD_CHAR: begin
          if (merge_r && item.char_code == CHAR_DOT) begin
            // dot joins the digit just stored, adding 0x80 flips bit 7
            for (int i = 0; i < DIGITS; i++) begin
              if (POS_W'(i) == last_pos) store_nxt[i][7] = ~store_r[i][7];
            end
            merge_nxt = 1'b0;
          end else if (done_r || wp_r >= POS_END) begin
            done_nxt  = 1'b1;
            merge_nxt = 1'b0;
          end else begin
            for (int i = 0; i < DIGITS; i++) begin
              if (POS_W'(i) == wp_r) store_nxt[i] = seg_lookup(item.char_code);
            end
            wp_nxt    = wp_inc;
            done_nxt  = (wp_inc >= POS_END);
            merge_nxt = 1'b1;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < DIGITS; i++) store_nxt[i] = 8'h00;
          merge_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_seg = 8'h00;
    for (int i = 0; i < DIGITS; i++) begin
      if (DIGIT_W'(i) == rd_digit) rd_seg = store_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) store_r[i] <= 8'h00;
      wp_r    <= '0;
      done_r  <= 1'b1;
      merge_r <= 1'b0;
    end else begin
      store_r <= store_nxt;
      wp_r    <= wp_nxt;
      done_r  <= done_nxt;
      merge_r <= merge_nxt;
    end
  end

  a_merge_pos: assert property (@(posedge clk) disable iff (!rst_n)
    merge_r |-> (wp_r >= POS_W'(1) && wp_r <= POS_END))
    else $error("dot merge armed with no stored digit before write position");

  a_open_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> wp_r < POS_END)
    else $error("writing enabled past the last digit");

endmodule

// File: rtl/core/ssd_scan.sv
module ssd_scan import ssd_pkg::*; #(
  parameter int DIGITS = 3,
  localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  logic                 tick,
  input  logic [PERIOD_W-1:0]  digit_period,
  input  logic [PERCENT_W-1:0] brightness_percent,
  output logic [DIGIT_W-1:0]   scan_digit,
  output logic                 lit
);

  localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGITS - 1);

  logic [PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic [DIGIT_W-1:0]  scan_digit_r, scan_digit_nxt;
  logic [PROD_W-1:0]   on_limit;
  logic [PROD_W-1:0]   count_scaled;

  always_comb begin
    tick_count_nxt = tick_count_r;
    scan_digit_nxt = scan_digit_r;
    if (upd && tick) begin
      if (tick_count_r >= digit_period) begin
        tick_count_nxt = '0;
        scan_digit_nxt = (scan_digit_r == LAST_DIGIT) ? '0 : scan_digit_r + DIGIT_W'(1);
      end else begin
        tick_count_nxt = tick_count_r + PERIOD_W'(1);
      end
    end
  end

  // count < period*percent/100  <=>  100*(count+1) <= period*percent
  assign on_limit     = PROD_W'(digit_period) * PROD_W'(brightness_percent);
  assign count_scaled = (PROD_W'(tick_count_nxt) + PROD_W'(1)) * PERCENT_FULL;
  assign lit          = (count_scaled <= on_limit);
  assign scan_digit   = scan_digit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      scan_digit_r <= '0;
    end else begin
      tick_count_r <= tick_count_nxt;
      scan_digit_r <= scan_digit_nxt;
    end
  end

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_digit_r <= LAST_DIGIT)
    else $error("scanned digit beyond the last digit");

endmodule

// File: rtl/core/seven_segment_scan_driver.sv
// Multiplexed seven-segment driver: start, character, clear and tick commands
// come in on the in_ channel, and every accepted command gives one result with
// the segment byte and digit select of the currently scanned digit, after the
// command took effect. A command passes an input register and then the result
// register, and either can hold it while the output is stalled; one command can
// be taken every clock while the output side keeps up, since the store update,
// table lookup and the one 16x7 brightness product all sit in the single stage
// between those two registers. Registers are written on
// cfg_write_en at cfg_index (0 digit period, 1 brightness percent, 2 segment
// active low, 3 digit active low) and should be changed only with no command
// in flight.
module seven_segment_scan_driver import ssd_pkg::*; #(
  parameter int DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [6:0]  in_char_code,
  input  logic [1:0]  in_start_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_segment_lines,
  output logic [2:0]  out_digit_selects,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [PERIOD_W-1:0]  digit_period_r;
  logic [PERCENT_W-1:0] brightness_percent_r;
  logic                 segment_active_low_r;
  logic                 digit_active_low_r;

  logic         s1_valid_r, s1_valid_nxt;
  item_t        s1_item_r;
  logic         s1_move;
  logic         in_xfer;

  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_seg_r;
  logic [SEL_W-1:0] out_sel_r;

  logic [DIGIT_W-1:0] scan_digit;
  logic               lit;
  logic [7:0]         seg_byte;
  logic [SEL_W-1:0]   sel_raw;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign in_xfer  = in_valid && in_ready;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  ssd_store #(.DIGITS(DIGITS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (s1_move),
    .item     (s1_item_r),
    .rd_digit (scan_digit),
    .rd_seg   (seg_byte)
  );

  ssd_scan #(.DIGITS(DIGITS)) u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .upd                (s1_move),
    .tick               (s1_item_r.cmd == CMD_TICK),
    .digit_period       (digit_period_r),
    .brightness_percent (brightness_percent_r),
    .scan_digit         (scan_digit),
    .lit                (lit)
  );

  // digits past the select width are never driven
  always_comb begin
    sel_raw = '0;
    for (int i = 0; i < SEL_W; i++) begin
      if (i < DIGITS && DIGIT_W'(i) == scan_digit) sel_raw[i] = lit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_period_r       <= PERIOD_RESET;
      brightness_percent_r <= PERCENT_RESET;
      segment_active_low_r <= 1'b0;
      digit_active_low_r   <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIGIT_PERIOD:       digit_period_r       <= cfg_data[PERIOD_W-1:0];
        CFG_BRIGHTNESS_PERCENT: brightness_percent_r <= cfg_data[PERCENT_W-1:0];
        CFG_SEGMENT_ACTIVE_LOW: segment_active_low_r <= cfg_data[0];
        CFG_DIGIT_ACTIVE_LOW:   digit_active_low_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= '{cmd: cmd_t'(in_cmd), char_code: in_char_code,
                     start_position: in_start_position};
    end
    if (s1_move) begin
      out_seg_r <= seg_byte ^ {8{segment_active_low_r}};
      out_sel_r <= sel_raw ^ {SEL_W{digit_active_low_r}};
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_lines = out_seg_r;
  assign out_digit_selects = out_sel_r;

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !digit_active_low_r) |-> $onehot0(out_sel_r))
    else $error("more than one digit selected");

endmodule
